// ----- design/ccfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared constants, types and the microcode program of the comb filter ring.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  // Defaults for the top-level parameters
  localparam int LINES_DEF       = 4;
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Register field formats
  localparam int DELAY_BITS = 13;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int PDATA_BITS = 32;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 13'd1024;

  // Program steps
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CAP  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_WR   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_FIN  = 2'd3;

  // Jump conditions
  localparam logic [1:0] COND_NEXT     = 2'd0;
  localparam logic [1:0] COND_NO_IN    = 2'd1;
  localparam logic [1:0] COND_NOT_LAST = 2'd2;
  localparam logic [1:0] COND_OUT_BUSY = 2'd3;

  typedef struct packed {
    logic              take;
    logic              cap;
    logic              wr;
    logic              fin;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic take;    // ready for an item, read line zero
    logic accept;  // item taken this cycle
    logic cap;     // capture read data
    logic wr;      // write next line, read it, advance line
    logic fin;     // load result, advance pointer
  } ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic last_line;
    logic out_busy;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '0;
    unique case (step)
      STEP_IDLE: begin
        cw.take   = 1'b1;
        cw.cond   = COND_NO_IN;
        cw.target = STEP_IDLE;
      end
      STEP_CAP: begin
        cw.cap    = 1'b1;
        cw.cond   = COND_NEXT;
        cw.target = STEP_WR;
      end
      STEP_WR: begin
        cw.wr     = 1'b1;
        cw.cond   = COND_NOT_LAST;
        cw.target = STEP_CAP;
      end
      STEP_FIN: begin
        cw.fin    = 1'b1;
        cw.cond   = COND_OUT_BUSY;
        cw.target = STEP_FIN;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- design/ccfr_ram.sv -----
// ----------------------------------------------------------------------------
// ccfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccfr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ccfr_seq.sv -----
// ----------------------------------------------------------------------------
// ccfr_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ccfr_seq
  import ccfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  in_ready
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            cw;
  logic              jump;

  assign cw = ucode_rom(step);

  always_comb begin
    unique case (cw.cond)
      COND_NEXT:     jump = 1'b0;
      COND_NO_IN:    jump = !in_valid;
      COND_NOT_LAST: jump = !stat.last_line;
      COND_OUT_BUSY: jump = stat.out_busy;
    endcase
    step_next = jump ? cw.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.take   = cw.take;
  assign ctrl.accept = cw.take & in_valid;
  assign ctrl.cap    = cw.cap;
  assign ctrl.wr     = cw.wr;
  assign ctrl.fin    = cw.fin & !stat.out_busy;
  assign in_ready    = cw.take;

endmodule

// ----- design/ccfr_dp.sv -----
// ----------------------------------------------------------------------------
// ccfr_dp
// Datapath: tap addressing, accumulate, feedback multiply, pointer and output.
// ----------------------------------------------------------------------------
module ccfr_dp
  import ccfr_pkg::*;
#(
  parameter int LINES       = LINES_DEF,
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ctrl_t                                      ctrl,
  output stat_t                                      stat,
  input  logic [LINES-1:0][DELAY_BITS-1:0]           delay,
  input  logic [LINES-1:0][GAIN_BITS-1:0]            gain,
  input  logic signed [SAMPLE_BITS-1:0]              sample_in,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [SAMPLE_BITS-1:0]              sample_out,
  output logic                                       ram_we,
  output logic [$clog2(LINES*MAX_DELAY)-1:0]         ram_waddr,
  output logic [SAMPLE_BITS-1:0]                     ram_wdata,
  output logic                                       ram_re,
  output logic [$clog2(LINES*MAX_DELAY)-1:0]         ram_raddr,
  input  logic [SAMPLE_BITS-1:0]                     ram_rdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int LINE_W = $clog2(LINES);
  localparam int PW     = $clog2(MAX_DELAY);
  localparam int EW     = $clog2(MAX_DELAY + 1);
  localparam int CW     = (DELAY_BITS > EW) ? DELAY_BITS : EW;
  localparam int AW     = $clog2(LINES * MAX_DELAY);
  localparam int PB     = SB + GAIN_BITS;

  localparam logic [EW:0]             MAXD_E  = (EW + 1)'(MAX_DELAY);
  localparam logic [CW-1:0]           MAXD_C  = CW'(MAX_DELAY);
  localparam logic [EW-1:0]           MAXD_F  = EW'(MAX_DELAY);
  localparam logic signed [PB:0]      RND     = (PB + 1)'(1) << (GAIN_FRAC - 1);
  localparam logic signed [SB-1:0]    SMAX    = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0]    SMIN    = {1'b1, {(SB - 1){1'b0}}};

  logic                  [LINE_W-1:0] line;
  logic                  [LINE_W-1:0] dst;
  logic                  [LINE_W-1:0] rd_line;
  logic                  [PW-1:0]     wp;
  logic                  [EW-1:0]     fill;
  logic signed           [SB-1:0]     x;
  logic signed           [SB-1:0]     acc;
  logic signed           [PB-1:0]     prod;
  logic                               rd_ok;

  logic                  [CW-1:0]     d_ext;
  logic                  [EW-1:0]     d_eff;
  logic                  [EW:0]       wrap_add;
  logic                  [EW:0]       off_sum;
  logic                  [PW-1:0]     off;

  logic signed           [SB-1:0]     tap;
  logic signed           [SB:0]       acc_sum;
  logic signed           [SB-1:0]     acc_sat;
  logic signed           [PB:0]       rnd;
  logic signed           [SB+2:0]     fb;
  logic signed           [SB+3:0]     wsum;
  logic signed           [SB-1:0]     wsat;

  // Line ring: the line after the last is line zero
  assign dst     = (line == LINE_W'(LINES - 1)) ? '0 : line + LINE_W'(1);
  assign rd_line = ctrl.wr ? dst : line;

  // Effective delay of the line being read
  always_comb begin
    d_ext = CW'(delay[rd_line]);
    if (d_ext == '0) begin
      d_eff = EW'(1);
    end else if (d_ext > MAXD_C) begin
      d_eff = MAXD_F;
    end else begin
      d_eff = EW'(d_ext);
    end
  end

  assign wrap_add = (EW'(wp) >= d_eff) ? '0 : MAXD_E;
  assign off_sum  = {1'b0, EW'(wp)} + wrap_add - {1'b0, d_eff};
  assign off      = off_sum[PW-1:0];

  assign ram_re    = ctrl.take | ctrl.wr;
  assign ram_raddr = AW'(rd_line) * AW'(MAX_DELAY) + AW'(off);

  // Capture: unwritten words read as zero
  assign tap     = rd_ok ? $signed(ram_rdata) : '0;
  assign acc_sum = {acc[SB-1], acc} + {tap[SB-1], tap};
  always_comb begin
    if (acc_sum[SB] != acc_sum[SB-1]) begin
      acc_sat = acc_sum[SB] ? SMIN : SMAX;
    end else begin
      acc_sat = acc_sum[SB-1:0];
    end
  end

  // Write: round half up, drop the fraction, add the input, saturate
  assign rnd  = {prod[PB-1], prod} + RND;
  assign fb   = rnd[PB:GAIN_FRAC];
  assign wsum = {{4{x[SB-1]}}, x} + {fb[SB+2], fb};
  always_comb begin
    if (!((&wsum[SB+3:SB-1]) || !(|wsum[SB+3:SB-1]))) begin
      wsat = wsum[SB+3] ? SMIN : SMAX;
    end else begin
      wsat = wsum[SB-1:0];
    end
  end

  assign ram_we    = ctrl.wr;
  assign ram_waddr = AW'(dst) * AW'(MAX_DELAY) + AW'(wp);
  assign ram_wdata = wsat;

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= (fill >= d_eff);
    end
    if (ctrl.accept) begin
      x   <= sample_in;
      acc <= '0;
    end
    if (ctrl.cap) begin
      acc  <= acc_sat;
      prod <= $signed(gain[dst]) * tap;
    end
    if (ctrl.fin) begin
      sample_out <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      wp        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.wr) begin
        line <= dst;
      end
      if (ctrl.fin) begin
        wp <= (wp == PW'(MAX_DELAY - 1)) ? '0 : wp + PW'(1);
        if (fill != MAXD_F) begin
          fill <= fill + EW'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.last_line = (line == LINE_W'(LINES - 1));
  assign stat.out_busy  = out_valid & !out_ready;

`ifndef SYNTHESIS
  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.fin |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken one");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.fin |=> out_valid)
    else $error("result not shown after finish");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= MAXD_F)
    else $error("fill count beyond delay depth");
  a_wp_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.fin |=> $stable(wp))
    else $error("write pointer moved outside finish");
  a_line_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.accept |-> (line == '0))
    else $error("item taken with line counter off zero");
`endif

endmodule

// ----- design/circular_comb_filter_ring_core.sv -----
// ----------------------------------------------------------------------------
// circular_comb_filter_ring_core
// Ring of feedback comb delay lines in one memory, driven by a microcoded
// sequencer, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each item is one Q1.(SAMPLE_BITS-1) sample. Every line k gives the word
// written delay_line k items ago; these taps are summed with saturation into
// sample_out. Line k's tap, times gain of the line after it (Q2.14, rounded
// half up), is added to the input, saturated and written into that next line
// (line zero after the last). Each line is read before it is written, so its
// delay is exactly its register: zero counts as one, anything above MAX_DELAY
// as MAX_DELAY. An item is worked as a take step, then a capture step and a
// write step per line, as the one memory read port and its registered read
// data are shared over the lines, then a finishing step loads the result. The
// finishing step holds while an earlier result is still waiting, so up to one
// result can sit at the output while the next item is being worked. There is
// no clearing pass: a fill count of items seen since reset marks which words
// have been written, and words not yet written read as zero. Registers sit at
// byte address 4*i: delay_line0..N-1, then gain_line0..N-1.
// ----------------------------------------------------------------------------
module circular_comb_filter_ring_core
  import ccfr_pkg::*;
#(
  parameter int LINES       = LINES_DEF,
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [$clog2(2*LINES)+1:0]      paddr,
  input  logic [PDATA_BITS-1:0]           pwdata,
  output logic [PDATA_BITS-1:0]           prdata,
  output logic                            pready,
  // input item
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  // result item
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   sample_out
);

  localparam int IDX_W = $clog2(2 * LINES);
  localparam int AW    = $clog2(LINES * MAX_DELAY);

  logic [LINES-1:0][DELAY_BITS-1:0] delay;
  logic [LINES-1:0][GAIN_BITS-1:0]  gain;
  logic [IDX_W-1:0]                 reg_idx;
  logic                             cfg_we;

  ctrl_t                            ctrl;
  stat_t                            stat;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [SAMPLE_BITS-1:0]           ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [SAMPLE_BITS-1:0]           ram_rdata;

  // Register port: no wait states, byte lanes ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[IDX_W+1:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  // Write: indexes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        delay[i] <= DELAY_RESET;
        gain[i]  <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < LINES; i++) begin
        if (reg_idx == IDX_W'(i)) begin
          delay[i] <= pwdata[DELAY_BITS-1:0];
        end
        if (reg_idx == IDX_W'(LINES + i)) begin
          gain[i] <= pwdata[GAIN_BITS-1:0];
        end
      end
    end
  end

  // Read back: delays zero-extended, gains sign-extended
  always_comb begin
    prdata = '0;
    for (int i = 0; i < LINES; i++) begin
      if (reg_idx == IDX_W'(i)) begin
        prdata = PDATA_BITS'(delay[i]);
      end
      if (reg_idx == IDX_W'(LINES + i)) begin
        prdata = {{(PDATA_BITS - GAIN_BITS){gain[i][GAIN_BITS-1]}}, gain[i]};
      end
    end
  end

  // Program sequencer
  ccfr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // Datapath
  ccfr_dp #(
    .LINES       (LINES),
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .delay      (delay),
    .gain       (gain),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Delay memory: line k occupies words k*MAX_DELAY onwards
  ccfr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINES * MAX_DELAY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- test/circular_comb_filter_ring_core_test.sv -----
// ----------------------------------------------------------------------------
// circular_comb_filter_ring_core_test
// Self-checking bench for the comb filter ring: drives samples through a
// valid/ready channel, predicts every output sample from a private copy of
// the delay memory, write pointer and registers, and compares each result.
// ----------------------------------------------------------------------------
module circular_comb_filter_ring_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccfr_pkg::*;

  localparam int NL         = LINES_DEF;
  localparam int MAXD       = MAX_DELAY_DEF;
  localparam int SB         = SAMPLE_BITS_DEF;
  localparam int AW         = $clog2(2*NL) + 2;
  localparam int REG_DELAY0 = 0;
  localparam int REG_GAIN0  = NL;
  // Settle long enough for an item to finish before touching registers.
  localparam int SETTLE_CYCLES  = 2*NL + 6;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [SB-1:0] sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          psel    = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite  = 1'b0;
  logic [AW-1:0] paddr   = '0;
  logic [31:0]   pwdata  = '0;
  logic [31:0]   prdata;
  logic          pready;

  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t sample_in = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t sample_out;

  // Samples waiting to be offered, and output samples predicted but not yet seen.
  sample_t samples_to_send[$];
  sample_t out_samples_due[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int fail_cnt      = 0;
  int quiet_cycles  = 0;

  // Private copy of the filter state.
  sample_t              ring_mem [NL*MAXD];
  int                   wr_ptr;
  logic [DELAY_BITS-1:0] delay_len [NL];
  logic signed [GAIN_BITS-1:0] fb_gain [NL];

  circular_comb_filter_ring_core u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to the signed sample range.
  function automatic sample_t clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SB-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return sample_t'(hi);
    if (v < lo) return sample_t'(lo);
    return sample_t'(v);
  endfunction

  // Advance the ring by one input sample and return the output sample it gives.
  // Read every line first, then write: each line's delay is exactly its register.
  function automatic sample_t filter_sample(input sample_t x);
    sample_t taps [NL];
    longint  acc;
    longint  fb;
    int      d;
    int      rd;
    int      dst;
    acc = 0;
    for (int k = 0; k < NL; k++) begin
      d = delay_len[k];
      // zero behaves as one, anything beyond the line as the full line
      if (d < 1) d = 1;
      else if (d > MAXD) d = MAXD;
      rd = (wr_ptr + MAXD - d) % MAXD;
      taps[k] = ring_mem[k*MAXD + rd];
      acc = clip(acc + taps[k]);
    end
    for (int k = 0; k < NL; k++) begin
      dst = (k + 1 < NL) ? k + 1 : 0;
      // Q2.14 gain product, rounded half up by an arithmetic shift
      fb = (longint'(fb_gain[dst]) * longint'(taps[k]) + (longint'(1) <<< (GAIN_FRAC-1)))
           >>> GAIN_FRAC;
      ring_mem[dst*MAXD + wr_ptr] = clip(longint'(x) + fb);
    end
    wr_ptr = (wr_ptr + 1) % MAXD;
    return sample_t'(acc);
  endfunction

  // One register write: setup phase, then access phase; pready is always high.
  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4*idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NL) delay_len[idx] = val[DELAY_BITS-1:0];
    else fb_gain[idx-NL] = val[GAIN_BITS-1:0];
  endtask

  task automatic write_line(input int k, input int dly, input int gain);
    reg_write(REG_DELAY0 + k, 32'(dly));
    reg_write(REG_GAIN0 + k, 32'(gain));
  endtask

  // Mostly short delays so the feedback shows up quickly; the rest hit the zero,
  // full-line and beyond-the-line cases or any length up to the line. Upper bits of the word are noise.
  function automatic logic [31:0] pick_delay();
    logic [31:0] w;
    int r;
    w = $urandom;
    r = $urandom_range(99);
    if (r < 60) w[DELAY_BITS-1:0] = DELAY_BITS'($urandom_range(1, 40));
    else if (r < 70) w[DELAY_BITS-1:0] = '0;
    else if (r < 78) w[DELAY_BITS-1:0] = DELAY_BITS'(MAXD);
    else if (r < 86) w[DELAY_BITS-1:0] = DELAY_BITS'($urandom_range(MAXD + 1, 8191));
    else w[DELAY_BITS-1:0] = DELAY_BITS'($urandom_range(1, MAXD));
    return w;
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] w;
    int r;
    w = $urandom;
    r = $urandom_range(99);
    if (r < 25) begin
      case ($urandom_range(6))
        0: w[15:0] = 16'sh8000;
        1: w[15:0] = 16'sh7fff;
        2: w[15:0] = 16'sd16384;
        3: w[15:0] = -16'sd16384;
        4: w[15:0] = 16'sd0;
        5: w[15:0] = 16'sd1;
        default: w[15:0] = -16'sd1;
      endcase
    end else if (r < 70) begin
      w[15:0] = 16'($urandom_range(0, 32768) - 16384);
    end
    return w;
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0: return {1'b0, {(SB-1){1'b1}}};
        1: return {1'b1, {(SB-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (r < 35) return sample_t'($urandom_range(0, 1023)) - sample_t'(512);
    return sample_t'($urandom);
  endfunction

  // Wait until every sample is taken and every result has come back, then let
  // the sequencer settle before the registers are touched.
  task automatic drain();
    while (samples_to_send.size() != 0 || out_samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: hold valid and payload until taken, predict on acceptance.
  always @(posedge clk) begin : drive_in
    logic holding;
    holding = in_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        out_samples_due.push_back(filter_sample(sample_in));
        void'(samples_to_send.pop_front());
        holding = 1'b0;
      end
      if (!holding) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid  <= 1'b1;
          sample_in <= samples_to_send[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, check each item against the oldest prediction.
  always @(posedge clk) begin : watch_out
    sample_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (out_samples_due.size() == 0) begin
          $error("sample_out: result with nothing pending, actual %0d", sample_out);
          fail_cnt++;
        end else begin
          want = out_samples_due.pop_front();
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out);
            fail_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Drop the run if nothing moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    sample_t mx;
    sample_t mn;
    mx = {1'b0, {(SB-1){1'b1}}};
    mn = {1'b1, {(SB-1){1'b0}}};
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr = 0;
    for (int k = 0; k < NL; k++) begin
      delay_len[k] = DELAY_RESET;
      fb_gain[k]   = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: long lines, no feedback, so the output stays at zero.
    samples_to_send.push_back(mx);
    samples_to_send.push_back(mn);
    samples_to_send.push_back('0);
    samples_to_send.push_back('1);
    drain();

    // Short lines with the gain extremes: drive the ring into saturation.
    write_line(0, 1, 16384);
    write_line(1, 2, -16384);
    write_line(2, 3, -32768);
    write_line(3, 1, 32767);
    repeat (4) samples_to_send.push_back(mx);
    repeat (4) samples_to_send.push_back(mn);
    samples_to_send.push_back('0);
    samples_to_send.push_back('1);
    samples_to_send.push_back(sample_t'(1));
    samples_to_send.push_back(sample_t'(24'h400000));
    drain();

    // Delay of zero, beyond the line, exactly the line, just past it.
    write_line(0, 0, -16384);
    write_line(1, 8191, 16384);
    write_line(2, MAXD, 0);
    write_line(3, MAXD + 1, -1);
    samples_to_send.push_back(mn);
    samples_to_send.push_back(mx);
    samples_to_send.push_back(mn);
    samples_to_send.push_back(mx);
    samples_to_send.push_back('1);
    drain();

    // Random settings, cycling through the idling patterns.
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      for (int k = 0; k < NL; k++) begin
        reg_write(REG_DELAY0 + k, pick_delay());
        reg_write(REG_GAIN0 + k, pick_gain());
      end
      repeat (80) samples_to_send.push_back(pick_sample());
      drain();
    end

    // Full-length and near-full lines next to a one-sample line, with feedback.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    reg_write(REG_DELAY0 + 0, 32'(MAXD));
    reg_write(REG_GAIN0 + 0, pick_gain());
    reg_write(REG_DELAY0 + 1, 32'(MAXD - 1));
    reg_write(REG_GAIN0 + 1, pick_gain());
    reg_write(REG_DELAY0 + 2, 32'(8191));
    reg_write(REG_GAIN0 + 2, pick_gain());
    reg_write(REG_DELAY0 + 3, 32'(1));
    reg_write(REG_GAIN0 + 3, pick_gain());
    repeat (40) samples_to_send.push_back(pick_sample());
    drain();

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
